// ----- rtl/lc3x_pkg.sv -----
package lc3x_pkg;

  // memory size and address width
  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // opcodes, standard numbering, plus the host write
  localparam logic [4:0] OP_BR   = 5'd0;
  localparam logic [4:0] OP_ADD  = 5'd1;
  localparam logic [4:0] OP_LD   = 5'd2;
  localparam logic [4:0] OP_ST   = 5'd3;
  localparam logic [4:0] OP_JSR  = 5'd4;
  localparam logic [4:0] OP_AND  = 5'd5;
  localparam logic [4:0] OP_LDR  = 5'd6;
  localparam logic [4:0] OP_STR  = 5'd7;
  localparam logic [4:0] OP_RTI  = 5'd8;
  localparam logic [4:0] OP_NOT  = 5'd9;
  localparam logic [4:0] OP_LDI  = 5'd10;
  localparam logic [4:0] OP_STI  = 5'd11;
  localparam logic [4:0] OP_JMP  = 5'd12;
  localparam logic [4:0] OP_RES  = 5'd13;
  localparam logic [4:0] OP_LEA  = 5'd14;
  localparam logic [4:0] OP_TRAP = 5'd15;
  localparam logic [4:0] OP_HOST = 5'd16;

  // condition codes
  localparam logic [2:0] CC_N = 3'd4;
  localparam logic [2:0] CC_Z = 3'd2;
  localparam logic [2:0] CC_P = 3'd1;

  typedef struct packed {
    logic [4:0]  op;
    logic [11:0] operand_bits;
    logic [15:0] host_address;
    logic [15:0] host_data;
  } in_t;

  typedef struct packed {
    logic [15:0] pc_after;
    logic [2:0]  cond_flags;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
    logic        trap_taken;
    logic [7:0]  trap_vector;
  } out_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'd0) f = CC_Z;
    else if (v[15]) f = CC_N;
    else f = CC_P;
    return f;
  endfunction

endpackage

// ----- rtl/lc3x_ram.sv -----
module lc3x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lc3_instruction_execute.sv -----
// Executes one LC-3 instruction (or a host memory write) per item and returns one
// result item each. After reset the block clears main memory, one word a cycle,
// before it accepts the first item. Register, branch, jump, trap, ST, STR and host
// write items can be accepted back to back while the output is not stalled. LD and
// LDR read memory and load the register in S_LD; STI reads the pointer and writes in
// S_STI; LDI reads the pointer, reads again in S_IND, then loads in S_LD. A result
// waits in an output register; while it is stalled the next item is held off.
module lc3_instruction_execute (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lc3x_pkg::in_t in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output lc3x_pkg::out_t out_item
);
  import lc3x_pkg::*;

  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_IND = 2'd1;
  localparam logic [1:0] S_LD  = 2'd2;
  localparam logic [1:0] S_STI = 2'd3;

  logic [1:0]  st, st_next;
  logic [MEM_AW:0] clr_cnt;
  logic        clearing;
  logic [15:0] regs [8];
  logic [15:0] pc, pc_next;
  logic [2:0]  cond, cond_next;
  logic [2:0]  pend_dr;
  logic        out_free, fire;

  logic [4:0]  op;
  logic [11:0] ib;
  logic [2:0]  dr, sr1, sr2;
  logic [15:0] off9, off6, imm5, off11, pc1, opnd2;

  logic        rw;
  logic [2:0]  ri;
  logic [15:0] rv;
  logic        load_out;
  out_t        res;

  logic              ram_we, ram_re;
  logic [MEM_AW-1:0] ram_wa, ram_ra;
  logic [15:0]       ram_wd, ram_rd;

  assign clearing = !clr_cnt[MEM_AW];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = clearing || (st != S_RUN) || !out_free;
  assign fire     = in_valid && !in_stall;

  // instruction fields
  assign op    = in_item.op;
  assign ib    = in_item.operand_bits;
  assign dr    = ib[11:9];
  assign sr1   = ib[8:6];
  assign sr2   = ib[2:0];
  assign off9  = {{7{ib[8]}}, ib[8:0]};
  assign off6  = {{10{ib[5]}}, ib[5:0]};
  assign imm5  = {{11{ib[4]}}, ib[4:0]};
  assign off11 = {{5{ib[10]}}, ib[10:0]};
  assign pc1   = (op <= OP_TRAP) ? pc + 16'd1 : pc;
  assign opnd2 = ib[5] ? imm5 : regs[sr2];

  // execute and sequence
  always_comb begin
    st_next   = st;
    pc_next   = pc;
    cond_next = cond;
    rw        = 1'b0;
    ri        = 3'd0;
    rv        = 16'd0;
    load_out  = 1'b0;
    res       = '0;
    ram_we    = 1'b0;
    ram_wa    = '0;
    ram_wd    = 16'd0;
    ram_re    = 1'b0;
    ram_ra    = '0;
    if (clearing) begin
      ram_we = 1'b1;
      ram_wa = clr_cnt[MEM_AW-1:0];
    end else begin
      unique case (st)
        S_RUN: begin
          if (fire) begin
            pc_next  = pc1;
            load_out = 1'b1;
            unique case (op)
              OP_BR: begin
                if ((cond & dr) != 3'd0) pc_next = pc1 + off9;
              end
              OP_ADD: begin
                rw = 1'b1; ri = dr; rv = regs[sr1] + opnd2;
              end
              OP_AND: begin
                rw = 1'b1; ri = dr; rv = regs[sr1] & opnd2;
              end
              OP_NOT: begin
                rw = 1'b1; ri = dr; rv = ~regs[sr1];
              end
              OP_LEA: begin
                rw = 1'b1; ri = dr; rv = pc1 + off9;
              end
              OP_JSR: begin
                ri = 3'd7; rv = pc1;
                pc_next = ib[11] ? pc1 + off11 : regs[sr1];
              end
              OP_JMP: pc_next = regs[sr1];
              OP_LD, OP_LDI, OP_STI: begin
                load_out = 1'b0;
                ram_re   = 1'b1;
                ram_ra   = MEM_AW'(pc1 + off9);
                st_next  = (op == OP_LD) ? S_LD : (op == OP_LDI) ? S_IND : S_STI;
              end
              OP_LDR: begin
                load_out = 1'b0;
                ram_re   = 1'b1;
                ram_ra   = MEM_AW'(regs[sr1] + off6);
                st_next  = S_LD;
              end
              OP_ST: begin
                ram_we = 1'b1; ram_wa = MEM_AW'(pc1 + off9); ram_wd = regs[dr];
                res.mem_write = 1'b1; res.mem_address = pc1 + off9; res.mem_value = regs[dr];
              end
              OP_STR: begin
                ram_we = 1'b1; ram_wa = MEM_AW'(regs[sr1] + off6); ram_wd = regs[dr];
                res.mem_write = 1'b1; res.mem_address = regs[sr1] + off6;
                res.mem_value = regs[dr];
              end
              OP_TRAP: begin
                res.trap_taken = 1'b1; res.trap_vector = ib[7:0];
              end
              OP_HOST: begin
                ram_we = 1'b1; ram_wa = MEM_AW'(in_item.host_address);
                ram_wd = in_item.host_data;
                res.mem_write = 1'b1; res.mem_address = in_item.host_address;
                res.mem_value = in_item.host_data;
              end
              default: ;
            endcase
            if (op == OP_JSR) begin
              res.reg_write = 1'b1; res.reg_index = ri; res.reg_value = rv;
            end
            if (rw) begin
              cond_next = flags_of(rv);
              res.reg_write = 1'b1; res.reg_index = ri; res.reg_value = rv;
            end
          end
        end
        S_IND: begin
          ram_re  = 1'b1;
          ram_ra  = ram_rd[MEM_AW-1:0];
          st_next = S_LD;
        end
        S_LD: begin
          if (out_free) begin
            rw = 1'b1; ri = pend_dr; rv = ram_rd;
            cond_next = flags_of(ram_rd);
            res.reg_write = 1'b1; res.reg_index = pend_dr; res.reg_value = ram_rd;
            load_out = 1'b1;
            st_next  = S_RUN;
          end
        end
        S_STI: begin
          if (out_free) begin
            ram_we = 1'b1; ram_wa = ram_rd[MEM_AW-1:0]; ram_wd = regs[pend_dr];
            res.mem_write = 1'b1; res.mem_address = ram_rd;
            res.mem_value = regs[pend_dr];
            load_out = 1'b1;
            st_next  = S_RUN;
          end
        end
        default: st_next = S_RUN;
      endcase
    end
    res.pc_after   = pc_next;
    res.cond_flags = cond_next;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_RUN;
      clr_cnt   <= '0;
      pc        <= 16'd0;
      cond      <= CC_Z;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= 16'd0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      st   <= st_next;
      pc   <= pc_next;
      cond <= cond_next;
      if (rw || (fire && op == OP_JSR)) regs[ri] <= rv;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fire) pend_dr <= dr;
    if (load_out) out_item <= res;
  end

  lc3x_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

endmodule
